FILE: rtl/assert_macros.svh
// Assertion helpers; both sample on the rising edge of clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define NVD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("nvd assertion failed");

// Checked at every edge, reset included.
`define NVD_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("nvd assertion failed");

`endif

FILE: rtl/nvd_pkg.sv
package nvd_pkg;

	localparam int ValueW   = 20;
	localparam int AccW     = 21;
	localparam int CountW   = 4;
	localparam int CodeW    = 5;
	localparam int OrdW     = 16;
	localparam int AsciiW   = 7;
	localparam int MaxNibblesDef = 7;

	localparam logic [CountW-1:0] CountSat  = 4'd15;
	localparam logic [CodeW-1:0]  LastCode  = 5'd25;
	localparam logic [AsciiW-1:0] BadLetter = 7'd65;

	typedef enum logic {
		OP_DATA  = 1'b0,
		OP_START = 1'b1
	} op_t;

	localparam logic [AsciiW-1:0] UNMAP [26] = '{
		7'd65, 7'd69, 7'd73, 7'd79, 7'd85, 7'd83, 7'd84, 7'd82, 7'd89,
		7'd72, 7'd75, 7'd66, 7'd67, 7'd68, 7'd70, 7'd71, 7'd74, 7'd76,
		7'd77, 7'd78, 7'd80, 7'd81, 7'd86, 7'd87, 7'd88, 7'd90
	};

	typedef struct packed {
		op_t                op;
		logic [7:0]         data_byte;
		logic [ValueW-1:0]  start_value;
		logic [CodeW-1:0]   bucket_code;
		logic [OrdW-1:0]    target_ordinal;
	} item_t;

	typedef struct packed {
		logic [AsciiW-1:0]  letter_a;
		logic [AsciiW-1:0]  letter_b;
		logic [AsciiW-1:0]  letter_c;
		logic [AsciiW-1:0]  letter_d;
		logic [AsciiW-1:0]  letter_e;
		logic [ValueW-1:0]  word_value;
		logic [OrdW-1:0]    ordinal;
		logic               hit;
		logic               bad_code;
		logic               last;
	} result_t;

	// One decoded word waiting in the output queue, before letter unmap.
	typedef struct packed {
		logic [ValueW-1:0]  word_value;
		logic [OrdW-1:0]    ordinal;
		logic               hit;
		logic               overrun;
		logic [CodeW-1:0]   bucket_letter;
		logic               last;
	} entry_t;

	typedef struct packed {
		logic [1:0]         n;
		entry_t             first;
		entry_t             second;
	} push_t;

	function automatic logic code_bad(input logic [CodeW-1:0] code);
		return code > LastCode;
	endfunction

	function automatic logic [AsciiW-1:0] unmap_letter(input logic [CodeW-1:0] code);
		if (code > LastCode) begin
			return BadLetter;
		end
		return UNMAP[code];
	endfunction

endpackage

FILE: rtl/nvd_item_if.sv
interface nvd_item_if import nvd_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/nvd_result_if.sv
interface nvd_result_if import nvd_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/nibble_varint_delta_word_decoder_unit.sv
// Delta-coded word decoder. A start transfer loads a bucket's base value,
// letter code and wanted ordinal; each data byte after it is decoded as two
// 3-bit nibble varints steps, low nibble first, and every finished varint
// yields one word result. One byte is taken per cycle while the queue has
// room for its words: the byte sits in an input register, both nibble steps
// resolve in one pass against the decoder state, and finished words go into
// a two-entry result queue; a result is offered once its byte's words are
// written there. The output gives one result per cycle while result.ready is
// high, so a byte that finishes two words waits until the queue drains to empty.
module nibble_varint_delta_word_decoder_unit import nvd_pkg::*; #(
	parameter int MAX_VARINT_NIBBLES = MaxNibblesDef
) (
	input  logic         clk,
	input  logic         arst_n,
	nvd_item_if.sink     item,
	nvd_result_if.source result
);

	push_t      push;
	logic [1:0] free;

	nvd_decode #(
		.MAX_VARINT_NIBBLES(MAX_VARINT_NIBBLES)
	) u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.free   (free),
		.push   (push)
	);

	nvd_result_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.free   (free),
		.result (result)
	);

endmodule

FILE: rtl/nvd_decode.sv
module nvd_decode import nvd_pkg::*; #(
	parameter int MAX_VARINT_NIBBLES = MaxNibblesDef
) (
	input  logic       clk,
	input  logic       arst_n,
	nvd_item_if.sink   item,
	input  logic [1:0] free,
	output push_t      push
);

	localparam logic [CountW-1:0] MaxCount = CountW'(MAX_VARINT_NIBBLES);

	logic              valid_s1;
	item_t             item_s1;
	logic              consume;

	logic [ValueW-1:0] value_q;
	logic [AccW-1:0]   acc_q;
	logic [CountW-1:0] count_q;
	logic [CodeW-1:0]  letter_q;
	logic [OrdW-1:0]   ord_q;
	logic [OrdW-1:0]   want_q;

	logic [3:0]        nib_lo, nib_hi;
	logic              fin_lo, fin_hi;
	logic [AccW-1:0]   acc_a, acc_mid, acc_b;
	logic [CountW-1:0] count_a, count_mid, count_b;
	logic [ValueW-1:0] value_a, value_mid, value_b;
	logic [OrdW-1:0]   ord_a, ord_mid, ord_b;
	entry_t            res_lo, res_hi;
	logic [1:0]        n_res;

	assign nib_lo = item_s1.data_byte[3:0];
	assign nib_hi = item_s1.data_byte[7:4];
	assign fin_lo = !nib_lo[3];
	assign fin_hi = !nib_hi[3];

	always_comb begin
		// low nibble
		acc_a   = {acc_q[AccW-4:0], nib_lo[2:0]};
		count_a = (count_q == CountSat) ? CountSat : count_q + 1'b1;
		value_a = value_q + acc_a[ValueW-1:0] + 1'b1;
		ord_a   = ord_q + 1'b1;

		acc_mid   = fin_lo ? '0 : acc_a;
		count_mid = fin_lo ? '0 : count_a;
		value_mid = fin_lo ? value_a : value_q;
		ord_mid   = fin_lo ? ord_a : ord_q;

		// high nibble continues from what the low one left
		acc_b   = {acc_mid[AccW-4:0], nib_hi[2:0]};
		count_b = (count_mid == CountSat) ? CountSat : count_mid + 1'b1;
		value_b = value_mid + acc_b[ValueW-1:0] + 1'b1;
		ord_b   = ord_mid + 1'b1;

		res_lo.word_value    = value_a;
		res_lo.ordinal       = ord_a;
		res_lo.hit           = (ord_a == want_q);
		res_lo.overrun       = (count_a > MaxCount);
		res_lo.bucket_letter = letter_q;
		res_lo.last          = !fin_hi;

		res_hi.word_value    = value_b;
		res_hi.ordinal       = ord_b;
		res_hi.hit           = (ord_b == want_q);
		res_hi.overrun       = (count_b > MaxCount);
		res_hi.bucket_letter = letter_q;
		res_hi.last          = 1'b1;

		n_res = (item_s1.op == OP_START) ? 2'd0 : {1'b0, fin_lo} + {1'b0, fin_hi};
	end

	assign consume    = valid_s1 && (free >= n_res);
	assign item.ready = !valid_s1 || consume;

	always_comb begin
		push.n      = consume ? n_res : 2'd0;
		push.first  = fin_lo ? res_lo : res_hi;
		push.second = res_hi;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q  <= '0;
			acc_q    <= '0;
			count_q  <= '0;
			letter_q <= '0;
			ord_q    <= '0;
			want_q   <= '0;
		end else if (consume) begin
			if (item_s1.op == OP_START) begin
				value_q  <= item_s1.start_value;
				letter_q <= item_s1.bucket_code;
				want_q   <= item_s1.target_ordinal;
				ord_q    <= '0;
				acc_q    <= '0;
				count_q  <= '0;
			end else begin
				value_q <= fin_hi ? value_b : value_mid;
				ord_q   <= fin_hi ? ord_b : ord_mid;
				acc_q   <= fin_hi ? '0 : acc_b;
				count_q <= fin_hi ? '0 : count_b;
			end
		end
	end

endmodule

FILE: rtl/nvd_result_queue.sv
module nvd_result_queue import nvd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  push_t       push,
	output logic [1:0]  free,
	nvd_result_if.source result
);

	entry_t     slot_q [2];
	entry_t     slot_d [2];
	logic [1:0] count_q;
	logic [1:0] count_pop;
	logic       pop;
	entry_t     head;

	assign pop       = result.valid && result.ready;
	assign count_pop = count_q - {1'b0, pop};
	assign free      = 2'd2 - count_pop;

	always_comb begin
		slot_d[0] = pop ? slot_q[1] : slot_q[0];
		slot_d[1] = slot_q[1];
		if (push.n != 2'd0) begin
			if (count_pop == 2'd0) begin
				slot_d[0] = push.first;
			end else begin
				slot_d[1] = push.first;
			end
		end
		// two results only arrive into an empty queue
		if (push.n == 2'd2) begin
			slot_d[1] = push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_pop + push.n;
		end
	end

	always_ff @(posedge clk) begin
		slot_q[0] <= slot_d[0];
		slot_q[1] <= slot_d[1];
	end

	assign head         = slot_q[0];
	assign result.valid = (count_q != 2'd0);

	always_comb begin
		result.data.letter_a   = unmap_letter(head.word_value[4:0]);
		result.data.letter_b   = unmap_letter(head.word_value[9:5]);
		result.data.letter_c   = unmap_letter(head.word_value[14:10]);
		result.data.letter_d   = unmap_letter(head.word_value[19:15]);
		result.data.letter_e   = unmap_letter(head.bucket_letter);
		result.data.word_value = head.word_value;
		result.data.ordinal    = head.ordinal;
		result.data.hit        = head.hit;
		result.data.bad_code   = head.overrun
			|| code_bad(head.word_value[4:0]) || code_bad(head.word_value[9:5])
			|| code_bad(head.word_value[14:10]) || code_bad(head.word_value[19:15])
			|| code_bad(head.bucket_letter);
		result.data.last       = head.last;
	end

endmodule

FILE: rtl/nvd_checker.sv
`include "assert_macros.svh"

module nvd_checker import nvd_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_ready,
	input logic              last,
	input logic [AsciiW-1:0] letter_a,
	input logic [AsciiW-1:0] letter_e
);

	// a held result stays offered until its transfer
	`NVD_ASSERT(a_hold, result_valid && !result_ready |=> result_valid)
	// second word of a byte is queued together with the first
	`NVD_ASSERT(a_pair, result_valid && result_ready && !last |=> result_valid)
	`NVD_ASSERT(a_letter_a, result_valid |-> letter_a >= 7'd65 && letter_a <= 7'd90)
	`NVD_ASSERT(a_letter_e, result_valid |-> letter_e >= 7'd65 && letter_e <= 7'd90)
	`NVD_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !result_valid)

endmodule

bind nibble_varint_delta_word_decoder_unit nvd_checker u_nvd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.last         (result.data.last),
	.letter_a     (result.data.letter_a),
	.letter_e     (result.data.letter_e)
);
